/* design/vl2n_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vl2n_pkg
// Shared widths, shifts and opcodes of the vector L2 normalizer.
// ----------------------------------------------------------------------------
package vl2n_pkg;

  localparam int MAX_DIM_DEF = 1024;   // default vector capacity
  localparam int ELEM_W      = 16;     // element and result width
  localparam int ROOT_W_DEF  = 31;     // root width at the default capacity

  localparam int SQ_SHIFT = 20;        // sum of squares is scaled by 2^20 before the root
  localparam int Q_BITS   = 16;        // quotient bits produced by the divider
  localparam int DIV_PRE  = 9;         // 25 - Q_BITS: dividend bits placed before the loop

  localparam logic [ELEM_W-1:0] Q_MAX = 16'd32767;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

endpackage

/* design/vl2n_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vl2n_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vl2n_ram #(
  parameter int WIDTH = vl2n_pkg::ELEM_W,
  parameter int DEPTH = vl2n_pkg::MAX_DIM_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/vl2n_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vl2n_isqrt
// Bit-serial integer square root: one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module vl2n_isqrt #(
  parameter int ROOT_W = vl2n_pkg::ROOT_W_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int RW    = ROOT_W + 2;
  localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic [2*ROOT_W-1:0] rad;
  logic [RW-1:0]       rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          fits;

  // next remainder takes the top two radicand bits; trial is 4*root + 1
  assign rem_sh = {rem[RW-3:0], rad[2*ROOT_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[2*ROOT_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
      cnt  <= cnt + CNT_W'(1);
    end
  end

endmodule

/* design/vector_l2_normalizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_l2_normalizer_unit
// L2 normalization of one vector of signed 16-bit elements in fixed point.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | in_valid / in_ready | opcode, element, is_last
//  output  | out_valid/out_ready | value (Q1.15), final_res, empty_res
//
//  Load: the element goes into the RAM, its square into the sum, while there is room.
//  A load marked last also runs the bit-serial root of sum << 20, holding the input
//  until the root is done.
//  Fetch: RAM read, 16 restoring divide steps, sign step and push. A fetch that
//  saturates or passes zeros through pushes after the read, an empty one at once.
//  One output register: the next word is taken while a result waits; PUSH stalls
//  only while it is full and not taken. Sync reset, no RAM sweep (read below count).
//
module vector_l2_normalizer_unit #(
  parameter int MAX_DIM = vl2n_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [vl2n_pkg::ELEM_W-1:0] element,
  input  logic                               is_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vl2n_pkg::ELEM_W-1:0] value,
  output logic                               final_res,
  output logic                               empty_res
);

  localparam int EW     = vl2n_pkg::ELEM_W;
  localparam int QB     = vl2n_pkg::Q_BITS;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SUM_W  = 2 * EW - 1 + $clog2(MAX_DIM);    // n * 2^30 at most
  localparam int RAD_W  = SUM_W + vl2n_pkg::SQ_SHIFT;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int DC_W   = $clog2(QB);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQRT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  rp;
  logic              vready;

  // fetch datapath
  logic              neg;
  logic [REM_W-1:0]  rem;
  logic [QB-1:0]     quo;
  logic [DC_W-1:0]   div_cnt;
  logic [EW-1:0]     res_value;
  logic              res_final;
  logic              res_empty;

  logic              acc;
  logic              is_load;
  logic [CNT_W-1:0]  base_count;
  logic [SUM_W-1:0]  base_sum;
  logic              room;
  logic [EW-1:0]     in_mag;
  logic [2*EW-1:0]   in_sq;
  logic [SUM_W-1:0]  sum_next;
  logic              fetch_hit;
  logic              out_free;

  logic [EW-1:0]     rd_data;
  logic [EW-1:0]     rd_mag;
  logic [REM_W-1:0]  rd_pre;
  logic [REM_W-1:0]  rem_sh;
  logic              rem_ge;
  logic [EW-1:0]     q_sat;

  logic              sq_start;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign is_load  = (opcode == vl2n_pkg::OP_LOAD);
  assign out_free = !out_valid || out_ready;

  // a load onto a finished vector starts over from an empty one
  assign base_count = vready ? '0 : count;
  assign base_sum   = vready ? '0 : sum;
  assign room       = base_count < CNT_W'(MAX_DIM);

  assign in_mag   = element[EW-1] ? EW'(~element + 1'b1) : EW'(element);
  assign in_sq    = in_mag * in_mag;
  assign sum_next = base_sum + (room ? SUM_W'(in_sq) : '0);

  assign fetch_hit = vready && (rp < count);
  assign sq_start  = acc && is_load && is_last;

  // divider: the quotient of (mag << 25) / root, top bits checked up front
  assign rd_mag = rd_data[EW-1] ? EW'(~rd_data + 1'b1) : rd_data;
  assign rd_pre = REM_W'(rd_mag) << vl2n_pkg::DIV_PRE;
  assign rem_sh = rem << 1;
  assign rem_ge = rem_sh >= REM_W'(root);
  assign q_sat  = quo[QB-1] ? vl2n_pkg::Q_MAX : quo;

  vl2n_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_DIM)
  ) u_store (
    .clk   (clk),
    .we    (acc && is_load && room),
    .waddr (base_count[AW-1:0]),
    .wdata (element),
    .re    (acc && !is_load && fetch_hit),
    .raddr (rp[AW-1:0]),
    .rdata (rd_data)
  );

  vl2n_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ((2*ROOT_W)'(sum_next) << vl2n_pkg::SQ_SHIFT),
    .done     (sq_done),
    .root     (sq_root)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      root      <= '0;
      rp        <= '0;
      vready    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register: filled from PUSH, emptied when its word is taken
      out_valid <= (state == S_PUSH && out_free) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_load) begin
              count  <= base_count + CNT_W'(room);
              sum    <= sum_next;
              rp     <= '0;
              vready <= is_last;
              if (is_last) begin
                state <= S_SQRT;
              end else begin
                root <= '0;
              end
            end else if (fetch_hit) begin
              rp    <= rp + CNT_W'(1);
              state <= S_RD;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            root  <= sq_root;
            state <= S_IDLE;
          end
        end
        S_RD: begin
          // zero sum: elements pass through; a quotient of 2^16 or more saturates
          if (root == '0 || rd_pre >= REM_W'(root)) begin
            state <= S_PUSH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == DC_W'(QB - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (acc && !is_load) begin
          res_value <= '0;
          res_final <= fetch_hit && ((rp + CNT_W'(1)) == count);
          res_empty <= !fetch_hit;
        end
      end
      S_RD: begin
        neg     <= rd_data[EW-1];
        rem     <= rd_pre;
        quo     <= '0;
        div_cnt <= '0;
        if (root == '0) begin
          res_value <= rd_data;
        end else if (rd_pre >= REM_W'(root)) begin
          res_value <= rd_data[EW-1] ? EW'(~vl2n_pkg::Q_MAX + 1'b1) : vl2n_pkg::Q_MAX;
        end
      end
      S_DIV: begin
        rem     <= rem_ge ? rem_sh - REM_W'(root) : rem_sh;
        quo     <= {quo[QB-2:0], rem_ge};
        div_cnt <= div_cnt + DC_W'(1);
      end
      S_FIN: begin
        res_value <= neg ? EW'(~q_sat + 1'b1) : q_sat;
      end
      S_PUSH: begin
        if (out_free) begin
          value     <= $signed(res_value);
          final_res <= res_final;
          empty_res <= res_empty;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/sv/vl2n_norm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vl2n_norm_checker
// Watches both channels of the L2 normalizer, predicts every fetch result
// from its own copy of the vector state and compares field by field.
// ----------------------------------------------------------------------------
module vl2n_norm_checker #(
  parameter int MAX_DIM = vl2n_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [vl2n_pkg::ELEM_W-1:0] element,
  input  logic                               is_last,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [vl2n_pkg::ELEM_W-1:0] value,
  input  logic                               final_res,
  input  logic                               empty_res,
  output int                                 fail_count,
  output int                                 pending
);

  // Q1.15 result of x / sqrt(sum << SQ_SHIFT): 15 fraction bits plus half the scale
  localparam int DIV_SHIFT = 15 + vl2n_pkg::SQ_SHIFT / 2;

  typedef struct packed {
    logic signed [vl2n_pkg::ELEM_W-1:0] value;
    logic                               final_res;
    logic                               empty_res;
  } norm_word_t;

  norm_word_t  norm_words_due[$];
  int          n_fail    = 0;
  int          n_pending = 0;

  // predicted vector state
  logic [vl2n_pkg::ELEM_W-1:0] elem_mem [MAX_DIM];
  int unsigned                 elem_cnt;
  int unsigned                 rd_ptr;
  logic [63:0]                 sq_sum;
  logic [63:0]                 norm_root;
  bit                          vec_done;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  task automatic note_mismatch(input string msg);
    $display("%0t ns  vl2n mismatch: %s", $time, msg);
    n_fail++;
  endtask

  always @(posedge clk) begin
    norm_word_t                  want;
    norm_word_t                  got;
    logic [vl2n_pkg::ELEM_W-1:0] x;
    logic [63:0]                 mag;
    logic [63:0]                 quo;
    logic [63:0]                 trial;
    logic [63:0]                 scaled;
    if (rst) begin
      elem_cnt  = 0;
      rd_ptr    = 0;
      sq_sum    = '0;
      norm_root = '0;
      vec_done  = 1'b0;
      norm_words_due.delete();
    end else begin
      // result side first: a word leaving now was predicted at an earlier edge
      if (out_valid && out_ready) begin
        got = '{value: value, final_res: final_res, empty_res: empty_res};
        if (norm_words_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word value=%0d final=%0b empty=%0b",
                                  got.value, got.final_res, got.empty_res));
        end else begin
          want = norm_words_due.pop_front();
          if (got.value !== want.value)
            note_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
          if (got.final_res !== want.final_res)
            note_mismatch($sformatf("final_res %0b, want %0b", got.final_res,
                                    want.final_res));
          if (got.empty_res !== want.empty_res)
            note_mismatch($sformatf("empty_res %0b, want %0b", got.empty_res,
                                    want.empty_res));
        end
      end

      if (in_valid && in_ready) begin
        if (opcode == vl2n_pkg::OP_LOAD) begin
          // a load after a closed vector starts over, dropping unread results
          if (vec_done) begin
            elem_cnt  = 0;
            rd_ptr    = 0;
            sq_sum    = '0;
            norm_root = '0;
            vec_done  = 1'b0;
          end
          if (elem_cnt < MAX_DIM) begin
            x   = element;
            mag = x[15] ? (64'h10000 - {48'b0, x}) : {48'b0, x};
            elem_mem[elem_cnt] = x;
            elem_cnt++;
            sq_sum += mag * mag;
          end
          if (is_last) begin
            // floor square root, one bit per step from the top
            scaled    = sq_sum << vl2n_pkg::SQ_SHIFT;
            norm_root = '0;
            for (int b = 31; b >= 0; b--) begin
              trial = norm_root | (64'd1 << b);
              if (trial * trial <= scaled) norm_root = trial;
            end
            rd_ptr   = 0;
            vec_done = 1'b1;
          end
        end else begin
          want = '{value: '0, final_res: 1'b0, empty_res: 1'b1};
          if (vec_done && rd_ptr < elem_cnt) begin
            x = elem_mem[rd_ptr];
            if (sq_sum == 0 || norm_root == 0) begin
              want.value = x;
            end else begin
              mag = x[15] ? (64'h10000 - {48'b0, x}) : {48'b0, x};
              quo = (mag << DIV_SHIFT) / norm_root;
              if (quo > vl2n_pkg::Q_MAX) quo = {48'b0, vl2n_pkg::Q_MAX};
              want.value = x[15] ? -quo[15:0] : quo[15:0];
            end
            want.final_res = (rd_ptr + 1 == elem_cnt);
            want.empty_res = 1'b0;
            rd_ptr++;
          end
          norm_words_due.push_back(want);
        end
      end
    end
    n_pending = norm_words_due.size();
  end

endmodule

/* tb/sv/vector_l2_normalizer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_l2_normalizer_unit_tb
// Drives load and fetch words into the L2 normalizer with random idle gaps
// on both sides; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module vector_l2_normalizer_unit_tb;

  localparam int MAX_DIM      = vl2n_pkg::MAX_DIM_DEF;
  localparam int RANDOM_ITEMS = 600;        // input words in the whole run
  localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
  localparam int DRAIN_CYCLES = 64;         // extra wait after the last expected word
  localparam int TIMEOUT_NS   = 6_000_000;  // several times the slowest run

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic                               in_ready;
  logic                               opcode    = vl2n_pkg::OP_LOAD;
  logic signed [vl2n_pkg::ELEM_W-1:0] element   = '0;
  logic                               is_last   = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [vl2n_pkg::ELEM_W-1:0] value;
  logic                               final_res;
  logic                               empty_res;

  int fail_count;
  int pending;

  // words taken on each channel; bumped at the rising edge, read at the falling one
  int in_words  = 0;
  int out_words = 0;

  // idle control shared by the sender, the receiver and the sequence
  bit in_no_idle  = 1'b0;
  bit out_no_idle = 1'b0;
  bit hold_output = 1'b0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vector_l2_normalizer_unit #(
    .MAX_DIM (MAX_DIM)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .element   (element),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .final_res (final_res),
    .empty_res (empty_res)
  );

  vl2n_norm_checker #(
    .MAX_DIM (MAX_DIM)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .element    (element),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .final_res  (final_res),
    .empty_res  (empty_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (in_valid && in_ready) in_words <= in_words + 1;
    if (out_valid && out_ready) out_words <= out_words + 1;
  end

  // Offer one word. Called at a falling edge, returns at the falling edge
  // right after the word was taken. Valid is only lowered for a real gap, so
  // back-to-back words never see valid drop and rise in the same step.
  task automatic send_word(input logic op, input logic signed [15:0] el,
                           input logic last);
    int gap;
    int seen;
    gap = in_no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    element  = el;
    is_last  = last;
    seen     = in_words;
    do @(negedge clk); while (in_words == seen);
  endtask

  // fetch ignores element and is_last, so they carry random bits
  task automatic fetch_word();
    send_word(vl2n_pkg::OP_FETCH, 16'($urandom), 1'($urandom));
  endtask

  // element shapes: full range, tiny, zero, or near the extremes
  function automatic logic signed [15:0] pick_element(input int style);
    case (style)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 16)) - 16'sd8;
      2:       return 16'sd0;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'($urandom_range(0, 3)) - 16'sd2;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  // Receiver: a random wait before each word, with no-idle stretches, and one
  // long hold-off on request so the block backs up into its input.
  initial begin
    int gap;
    int seen;
    wait (!rst);
    forever begin
      if (hold_output) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      gap = out_no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      seen      = out_words;
      do @(negedge clk); while (out_words == seen && !hold_output);
    end
  end

  // hard stop if the block hangs
  initial begin
    #TIMEOUT_NS;
    $display("** vector_l2_normalizer_unit: FAILED **");
    $finish;
  end

  initial begin
    int len;
    int style;
    int n_fetch;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed ----------------------------------------------------------
    // nothing loaded yet: fetch reports empty
    send_word(vl2n_pkg::OP_FETCH, 16'sh7fff, 1'b1);

    // field extremes in one vector; the sixth fetch runs past the end
    send_word(vl2n_pkg::OP_LOAD, 16'sh7fff, 1'b0);
    send_word(vl2n_pkg::OP_LOAD, 16'sh8000, 1'b0);
    send_word(vl2n_pkg::OP_LOAD, 16'sd0, 1'b0);
    send_word(vl2n_pkg::OP_LOAD, 16'sd1, 1'b0);
    send_word(vl2n_pkg::OP_LOAD, -16'sd1, 1'b1);
    repeat (6) fetch_word();

    // all-zero vector: elements come back raw
    send_word(vl2n_pkg::OP_LOAD, 16'sd0, 1'b0);
    send_word(vl2n_pkg::OP_LOAD, 16'sd0, 1'b1);
    repeat (3) fetch_word();

    // one element equal to the whole norm: quotient clamps to -32767
    send_word(vl2n_pkg::OP_LOAD, 16'sh8000, 1'b1);
    fetch_word();

    // fetch while a vector is still open is empty; then read part of a
    // vector and let a new load throw the rest away
    send_word(vl2n_pkg::OP_LOAD, 16'sd100, 1'b0);
    fetch_word();
    send_word(vl2n_pkg::OP_LOAD, -16'sd200, 1'b1);
    fetch_word();
    send_word(vl2n_pkg::OP_LOAD, 16'sd7, 1'b1);
    fetch_word();

    // ---- back pressure -----------------------------------------------------
    // receiver holds off while fetches keep coming, so the block fills up
    hold_output = 1'b1;
    in_no_idle  = 1'b1;
    for (int i = 0; i < 8; i++)
      send_word(vl2n_pkg::OP_LOAD, pick_element(0), i == 7);
    repeat (8) fetch_word();

    // ---- random ------------------------------------------------------------
    // mostly well-formed vectors with a read-back, plus partial reads,
    // overruns, fetches mid-load and raw noise words
    while (in_words < RANDOM_ITEMS) begin
      in_no_idle  = ($urandom_range(0, 4) == 0);
      out_no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(1'($urandom), 16'($urandom), 1'($urandom));
      end
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 15) == 0) fetch_word();
        send_word(vl2n_pkg::OP_LOAD, pick_element(style), i == len - 1);
      end
      case ($urandom_range(0, 5))
        0:       n_fetch = $urandom_range(0, len);
        1:       n_fetch = len + $urandom_range(1, 3);
        default: n_fetch = len;
      endcase
      repeat (n_fetch) fetch_word();
    end
    in_valid = 1'b0;

    // ---- drain and verdict -------------------------------------------------
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** vector_l2_normalizer_unit: PASSED **");
    end else begin
      $display("** vector_l2_normalizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
